/* rtl/core/assert_macros.svh */
// Assertion macros shared by the decoder RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define ASSERT_NEXT(label, clk, rst_n, cond, expr)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

/* rtl/core/htd_pkg.sv */
// Constants and tree tables for the Huffman tree text decoder.
// No dependencies; used by htd_tree_rom and the top level.
package htd_pkg;

  localparam int unsigned TREE_ROM_DEPTH = 102;
  localparam int unsigned TBL_A_LEN = 102;
  localparam int unsigned TBL_B_LEN = 100;
  localparam int unsigned MAX_RESULTS = 4;

  localparam logic [7:0] NODE_FLAG = 8'h80;
  localparam logic [7:0] LOW7_MASK = 8'h7F;

  localparam logic [7:0] TREE_A [0:TBL_A_LEN-1] = '{
    8'ha1, 8'h81, 8'h8b, 8'h81, 8'h5e, 8'h81, 8'h81, 8'h45,
    8'h81, 8'h52, 8'h81, 8'h44, 8'h81, 8'h56, 8'h4b, 8'h81,
    8'h81, 8'h30, 8'h81, 8'h2d, 8'h81, 8'h4a, 8'h36, 8'h38,
    8'h81, 8'h20, 8'h83, 8'h81, 8'h81, 8'h48, 8'h59, 8'h43,
    8'h82, 8'h81, 8'h4d, 8'h57, 8'h81, 8'h2e, 8'h81, 8'h42,
    8'h84, 8'h81, 8'h31, 8'h81, 8'h5a, 8'h81, 8'h34, 8'h33,
    8'h86, 8'h81, 8'h51, 8'h81, 8'h81, 8'h32, 8'h81, 8'h25,
    8'h2b, 8'h81, 8'h23, 8'h28, 8'h81, 8'h3f, 8'h39, 8'h81,
    8'h37, 8'h2a, 8'h86, 8'h81, 8'h84, 8'h81, 8'h54, 8'h81,
    8'h81, 8'h4c, 8'h50, 8'h46, 8'h53, 8'h4f, 8'h82, 8'h81,
    8'h4e, 8'h41, 8'h49, 8'h81, 8'h81, 8'h55, 8'h81, 8'h47,
    8'h2c, 8'h81, 8'h81, 8'h58, 8'h27, 8'h81, 8'h81, 8'h21,
    8'h35, 8'h81, 8'h26, 8'h81, 8'h29, 8'h2f
  };

  localparam logic [7:0] TREE_B [0:TBL_B_LEN-1] = '{
    8'h9c, 8'h81, 8'h96, 8'h81, 8'h81, 8'h20, 8'h83, 8'h81,
    8'h81, 8'h48, 8'h59, 8'h43, 8'h82, 8'h81, 8'h4d, 8'h57,
    8'h81, 8'h2e, 8'h81, 8'h42, 8'h84, 8'h81, 8'h31, 8'h81,
    8'h5a, 8'h81, 8'h34, 8'h33, 8'h86, 8'h81, 8'h51, 8'h81,
    8'h81, 8'h32, 8'h81, 8'h25, 8'h2b, 8'h81, 8'h23, 8'h28,
    8'h81, 8'h3f, 8'h39, 8'h81, 8'h37, 8'h2a, 8'h84, 8'h81,
    8'h54, 8'h81, 8'h81, 8'h4c, 8'h50, 8'h46, 8'h53, 8'h4f,
    8'h8d, 8'h81, 8'h82, 8'h81, 8'h4e, 8'h41, 8'h49, 8'h81,
    8'h81, 8'h55, 8'h81, 8'h47, 8'h2c, 8'h81, 8'h81, 8'h58,
    8'h27, 8'h81, 8'h81, 8'h21, 8'h35, 8'h81, 8'h26, 8'h81,
    8'h29, 8'h2f, 8'h81, 8'h45, 8'h81, 8'h52, 8'h81, 8'h44,
    8'h81, 8'h56, 8'h4b, 8'h81, 8'h81, 8'h30, 8'h81, 8'h2d,
    8'h81, 8'h4a, 8'h36, 8'h38
  };

endpackage

/* rtl/core/huffman_tree_text_decoder_unit.sv */
// Huffman tree text decoder: code bits are shifted out one per cycle while the output has room, and walk the tree.
// A decoded character is registered in the output register; a held result stalls the walker.
// A msg_start byte supplies one code bit and any other byte eight; a new byte is accepted
// only when idle, once all its bits are walked or the char count is or becomes zero.
// Reset (rst_n, synchronous, active low) clears the walk, the count and table_select.
`include "assert_macros.svh"

module huffman_tree_text_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,     // table_select
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,      // [7:0] data_byte, [15:8] char_count
  input  logic        in_tuser,      // msg_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,     // [6:0] char_out, [7] zero
  output logic        out_tlast      // last_char
);

  logic       sel_r, sel_nxt;
  logic       busy_r, busy_nxt;
  logic [7:0] bits_r, bits_nxt;
  logic [3:0] nbits_r, nbits_nxt;
  logic [6:0] offset_r, offset_nxt;
  logic [7:0] left_r, left_nxt;
  logic [2:0] res_cnt_r, res_cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [6:0] out_char_r, out_char_nxt;
  logic       out_last_r, out_last_nxt;

  logic       accept;
  logic       room;
  logic       step;
  logic       emit;
  logic       is_leaf;
  logic [7:0] idx;
  logic [7:0] entry;

  htd_tree_rom u_rom (
    .idx     (idx),
    .tbl_sel (sel_r),
    .entry   (entry)
  );

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !busy_r;
  assign room      = !out_valid_r || out_tready;
  assign idx       = {1'b0, offset_r} + {7'd0, bits_r[7]};
  assign is_leaf   = (entry & htd_pkg::NODE_FLAG) == 8'h00;
  assign step      = busy_r && (left_r != 8'd0) && room;
  assign emit      = step && is_leaf && (res_cnt_r < 3'(htd_pkg::MAX_RESULTS));

  always_comb begin
    sel_nxt       = sel_r;
    busy_nxt      = busy_r;
    bits_nxt      = bits_r;
    nbits_nxt     = nbits_r;
    offset_nxt    = offset_r;
    left_nxt      = left_r;
    res_cnt_nxt   = res_cnt_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    if (cfg_we) begin
      sel_nxt = cfg_wdata;
    end

    if (accept) begin
      busy_nxt    = 1'b1;
      res_cnt_nxt = 3'd0;
      if (in_tuser) begin
        left_nxt   = in_tdata[15:8];
        offset_nxt = 7'd0;
        bits_nxt   = {in_tdata[7], 7'd0};
        nbits_nxt  = 4'd1;
      end else begin
        bits_nxt  = {in_tdata[6:0], in_tdata[7]};
        nbits_nxt = 4'd8;
      end
    end else if (busy_r && (left_r == 8'd0)) begin
      busy_nxt = 1'b0;
    end else if (step) begin
      bits_nxt  = {bits_r[6:0], 1'b0};
      nbits_nxt = nbits_r - 4'd1;
      if (nbits_r == 4'd1) begin
        busy_nxt = 1'b0;
      end
      if (is_leaf) begin
        offset_nxt = 7'd0;
      end else begin
        offset_nxt = offset_r + {entry[5:0], 1'b0};
      end
      if (emit) begin
        left_nxt    = left_r - 8'd1;
        res_cnt_nxt = res_cnt_r + 3'd1;
      end
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = entry[6:0] & htd_pkg::LOW7_MASK[6:0];
      out_last_nxt  = left_r == 8'd1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= 1'b0;
      busy_r      <= 1'b0;
      nbits_r     <= 4'd0;
      offset_r    <= 7'd0;
      left_r      <= 8'd0;
      res_cnt_r   <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      sel_r       <= sel_nxt;
      busy_r      <= busy_nxt;
      nbits_r     <= nbits_nxt;
      offset_r    <= offset_nxt;
      left_r      <= left_nxt;
      res_cnt_r   <= res_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r     <= bits_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_last_r;

  `ASSERT_NEXT(a_idle_when_count_done, clk, rst_n, busy_r && (left_r == 8'd0), !busy_r)
  `ASSERT_NEXT(a_last_char, clk, rst_n, emit && (left_r == 8'd1), out_tvalid && out_tlast && ~|left_r)
  `ASSERT_NEVER(a_result_cap, clk, rst_n, res_cnt_r > 3'(htd_pkg::MAX_RESULTS))
  `ASSERT_IMPLIES(a_no_step_when_blocked, clk, rst_n, out_valid_r && !out_tready, !emit)

endmodule

/* rtl/core/htd_tree_rom.sv */
// Tree table lookup: selects one of the two trees and bounds the index.
// Depends on htd_pkg. Entries outside the selected tree read as zero.
module htd_tree_rom (
  input  logic [7:0] idx,
  input  logic       tbl_sel,
  output logic [7:0] entry
);

  logic in_depth;
  logic in_a;
  logic in_b;

  assign in_depth = {1'b0, idx} < 9'(htd_pkg::TREE_ROM_DEPTH);
  assign in_a     = idx < 8'(htd_pkg::TBL_A_LEN);
  assign in_b     = idx < 8'(htd_pkg::TBL_B_LEN);

  always_comb begin
    entry = 8'h00;
    if (in_depth) begin
      if (tbl_sel) begin
        if (in_b) begin
          entry = htd_pkg::TREE_B[idx[6:0]];
        end
      end else begin
        if (in_a) begin
          entry = htd_pkg::TREE_A[idx[6:0]];
        end
      end
    end
  end

endmodule
